[rtl/core/dpcc_pkg.sv]
// ----------------------------------------------------------------------------
// dpcc_pkg
// Shared types, codes and constants for the dual pump cyclic controller.
// ----------------------------------------------------------------------------
package dpcc_pkg;

  // timer and pwm sizing
  localparam int TIMER_BITS = 24;
  localparam int PWM_TOP    = 400;
  localparam int PCT_MAX    = 100;
  localparam int PWM_SCALE  = PWM_TOP / PCT_MAX;

  // command codes
  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_SET_BOTH    = 3'd1,
    OP_SET_DIAPH   = 3'd2,
    OP_SET_PISTON  = 3'd3,
    OP_TOGGLE_MODE = 3'd4,
    OP_OPEN_VALVE  = 3'd5,
    OP_CLOSE_VALVE = 3'd6
  } opcode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_PISTON_REJECT  = 2'd1,
    ST_BOTH_REJECT    = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_INTERVAL   = 2'd0,
    REG_DURATION   = 2'd1,
    REG_PISTON_PCT = 2'd2
  } reg_index_t;

  // input beat
  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [15:0] value;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [8:0] diaphragm_compare;
    logic [8:0] piston_compare;
    logic [6:0] diaphragm_level;
    logic [6:0] piston_level;
    logic       valve_is_open;
    logic       cyclic_active;
    logic       piston_on_phase;
    logic [1:0] status;
  } out_item_t;

  // configuration register set
  typedef struct packed {
    logic [TIMER_BITS-1:0] interval;
    logic [TIMER_BITS-1:0] duration;
    logic [6:0]            cyc_duty;
  } cfg_regs_t;

  // controller state
  typedef struct packed {
    logic                  mode_cyclic;
    logic                  cycle_on;
    logic [6:0]            diaph_duty;
    logic [6:0]            piston_duty;
    logic                  valve_state;
    logic [TIMER_BITS-1:0] since_start;
  } ctrl_state_t;

  // percentage to pwm compare value
  function automatic logic [8:0] to_compare(input logic [6:0] pct);
    logic [11:0] prod;
    prod = 12'(pct) * 12'(PWM_SCALE);
    return prod[8:0];
  endfunction

endpackage

[rtl/core/dpcc_step.sv]
// ----------------------------------------------------------------------------
// dpcc_step
// Next-state and result logic for one beat: timer advance, cyclic check,
// then the command.
// ----------------------------------------------------------------------------
module dpcc_step
  import dpcc_pkg::*;
(
  input  in_item_t    item,
  input  cfg_regs_t   cfg,
  input  ctrl_state_t cur,
  output ctrl_state_t nxt,
  output out_item_t   result
);

  logic [6:0]            pct_clamped;
  logic [6:0]            cyc_pct;
  logic [TIMER_BITS-1:0] cnt_tick;
  ctrl_state_t           timed;
  status_t               status;

  // clamp signed request to 0..100
  always_comb begin
    if (item.value < 0) begin
      pct_clamped = 7'd0;
    end else if (item.value > 16'(PCT_MAX)) begin
      pct_clamped = 7'(PCT_MAX);
    end else begin
      pct_clamped = item.value[6:0];
    end
    cyc_pct = (cfg.cyc_duty > 7'(PCT_MAX)) ? 7'(PCT_MAX) : cfg.cyc_duty;
  end

  // saturating millisecond counter
  always_comb begin
    cnt_tick = cur.since_start;
    if (opcode_t'(item.opcode) == OP_TICK && cur.since_start != '1) begin
      cnt_tick = cur.since_start + 1'b1;
    end
  end

  // cyclic start and stop check
  always_comb begin
    timed             = cur;
    timed.since_start = cnt_tick;
    if (cur.mode_cyclic && cfg.interval != '0) begin
      if (!cur.cycle_on && cnt_tick >= cfg.interval) begin
        timed.since_start = '0;
        timed.cycle_on    = 1'b1;
        timed.piston_duty = cyc_pct;
      end else if (cur.cycle_on && cnt_tick >= cfg.duration) begin
        timed.cycle_on    = 1'b0;
        timed.piston_duty = 7'd0;
      end
    end
  end

  // command
  always_comb begin
    nxt    = timed;
    status = ST_OK;
    case (opcode_t'(item.opcode))
      OP_SET_BOTH: begin
        if (timed.mode_cyclic) begin
          status = ST_BOTH_REJECT;
        end else begin
          nxt.diaph_duty  = pct_clamped;
          nxt.piston_duty = pct_clamped;
        end
      end
      OP_SET_DIAPH: nxt.diaph_duty = pct_clamped;
      OP_SET_PISTON: begin
        if (timed.mode_cyclic) begin
          status = ST_PISTON_REJECT;
        end else begin
          nxt.piston_duty = pct_clamped;
        end
      end
      OP_TOGGLE_MODE: begin
        if (timed.mode_cyclic) begin
          nxt.mode_cyclic = 1'b0;
          nxt.cycle_on    = 1'b0;
          nxt.piston_duty = 7'd0;
        end else begin
          nxt.mode_cyclic = 1'b1;
        end
      end
      OP_OPEN_VALVE:  nxt.valve_state = 1'b1;
      OP_CLOSE_VALVE: nxt.valve_state = 1'b0;
      default: ;
    endcase
  end

  // result fields from the updated state
  always_comb begin
    result.diaphragm_compare = to_compare(nxt.diaph_duty);
    result.piston_compare    = to_compare(nxt.piston_duty);
    result.diaphragm_level   = nxt.diaph_duty;
    result.piston_level      = nxt.piston_duty;
    result.valve_is_open     = nxt.valve_state;
    result.cyclic_active     = nxt.mode_cyclic;
    result.piston_on_phase   = nxt.cycle_on;
    result.status            = status;
  end

endmodule

[rtl/core/dual_pump_cyclic_controller_core.sv]
// ----------------------------------------------------------------------------
// dual_pump_cyclic_controller_core
// Two-pump duty controller with a cyclic piston mode and a valve drive.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready/in_data): one tick or command per beat.
//   out channel (out_valid/out_ready/out_data): exactly one result beat per
//   input beat, in order, showing the state after that beat.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always ready; write only while the block is idle.
// Output: each result is registered, in the result register or in the skid entry.
// Throughput: one beat per cycle while the skid entry is empty; the state update
//   is a single compare and add stage between the accepted beat and the result register.
// Stall: a two-entry output buffer (result register plus skid) lets one
//   more beat in while the receiver stalls; in_ready drops once the skid
//   entry is full and returns as soon as the receiver takes a beat.
// Reset: synchronous; clears mode, levels, valve, timer and the output
//   buffer, and restores the registers to interval 0, duration 0, level 100.
// ----------------------------------------------------------------------------
module dual_pump_cyclic_controller_core
  import dpcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [23:0] cfg_data
);

  cfg_regs_t   cfg;
  ctrl_state_t state;
  ctrl_state_t state_next;
  out_item_t   result;
  out_item_t   skid;
  logic        skid_valid;
  logic        in_fire;
  logic        out_fire;

  assign in_ready  = !skid_valid;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval <= '0;
      cfg.duration <= '0;
      cfg.cyc_duty <= 7'(PCT_MAX);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_INTERVAL:   cfg.interval <= cfg_data[TIMER_BITS-1:0];
        REG_DURATION:   cfg.duration <= cfg_data[TIMER_BITS-1:0];
        REG_PISTON_PCT: cfg.cyc_duty <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // per-beat update logic
  dpcc_step u_step (
    .item   (in_data),
    .cfg    (cfg),
    .cur    (state),
    .nxt    (state_next),
    .result (result)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_fire) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_fire;
        end
      end else if (in_fire) begin
        if (out_valid) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  // output buffer payload
  always_ff @(posedge clk) begin
    if (out_fire && skid_valid) begin
      out_data <= skid;
    end else if (in_fire && (out_fire || !out_valid)) begin
      out_data <= result;
    end
    if (in_fire && out_valid && !out_fire) begin
      skid <= result;
    end
  end

`ifndef ASSERT_OFF
  // skid entry only fills behind a held result
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without result register");

  // an activation can only run in cyclic mode
  a_cycle_in_mode : assert property (@(posedge clk) disable iff (rst)
    state.cycle_on |-> state.mode_cyclic)
    else $error("cycle running outside cyclic mode");

  // rejections only happen in cyclic mode
  a_reject_in_mode : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_OK) |-> out_data.cyclic_active)
    else $error("command rejected in manual mode");

  // a full buffer blocks new beats
  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_ready) |=> skid_valid)
    else $error("skid entry lost while receiver stalled");
`endif

endmodule

[tb/dual_pump_cyclic_controller_core_tb.sv]
// ----------------------------------------------------------------------------
// dual_pump_cyclic_controller_core_tb
// Self-checking bench for the pump controller core. A directed table covers
// the level clamps, every command, rejects in cyclic mode and the unused
// opcode. Random phases follow under several timing setups, zero and
// extreme ones included. Result beats are checked against a cycle-free model
// of the controller, or against the table readout for a typed row.
// ----------------------------------------------------------------------------
module dual_pump_cyclic_controller_core_tb;
  import dpcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CLK_HALF       = 4;
  localparam int         RESULT_LATENCY = 1;
  localparam int         STALL_LIMIT    = 2000;
  localparam int         ITEMS_PER_SET  = 215;
  localparam logic [2:0] OP_UNUSED      = 3'd7;
  localparam logic [1:0] REG_UNMAPPED   = 2'd3;
  localparam logic [23:0] MS_MAX        = 24'hFFFFFF;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  // directed stimulus row; a typed readout is checked in place of the model
  typedef struct {
    in_item_t  cmd;
    bit        typed;
    out_item_t readout;
  } cmd_row_t;

  cmd_row_t  cmd_table[$];
  out_item_t pending_readouts[$];
  int        error_count;
  int        idle_cycles;
  bit        steady_flow;

  // controller model state and its registers
  logic        mdl_cyclic;
  logic        mdl_cycle_on;
  logic [6:0]  mdl_diaph_pct;
  logic [6:0]  mdl_piston_duty;
  logic        mdl_valve;
  logic [23:0] mdl_ms_count;
  logic [23:0] mdl_interval;
  logic [23:0] mdl_duration;
  logic [6:0]  mdl_cyc_level;

  dual_pump_cyclic_controller_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  function automatic logic [8:0] pct_to_compare(input logic [6:0] pct);
    return 9'((int'(pct) * PWM_TOP) / PCT_MAX);
  endfunction

  function automatic out_item_t mk_readout(input int dc, input int pc, input int dl,
                                           input int pl, input bit valve,
                                           input bit cyc, input bit on,
                                           input status_t st);
    out_item_t r;
    r.diaphragm_compare = 9'(dc);
    r.piston_compare    = 9'(pc);
    r.diaphragm_level   = 7'(dl);
    r.piston_level      = 7'(pl);
    r.valve_is_open     = valve;
    r.cyclic_active     = cyc;
    r.piston_on_phase   = on;
    r.status            = st;
    return r;
  endfunction

  // advance the controller model by one beat and return its readout
  function automatic out_item_t next_pump_readout(input in_item_t cmd);
    int         req;
    logic [6:0] pct;
    status_t    st;
    out_item_t  r;
    req = $signed(cmd.value);
    pct = (req < 0) ? 7'd0 : (req > PCT_MAX) ? 7'(PCT_MAX) : 7'(req);
    st  = ST_OK;
    // ms tick, saturating
    if (cmd.opcode == OP_TICK && mdl_ms_count != MS_MAX)
      mdl_ms_count = mdl_ms_count + 24'd1;
    // cyclic start, else stop
    if (mdl_cyclic && mdl_interval != 24'd0) begin
      if (!mdl_cycle_on && mdl_ms_count >= mdl_interval) begin
        mdl_ms_count    = 24'd0;
        mdl_cycle_on    = 1'b1;
        mdl_piston_duty = (mdl_cyc_level > 7'(PCT_MAX)) ? 7'(PCT_MAX) : mdl_cyc_level;
      end else if (mdl_cycle_on && mdl_ms_count >= mdl_duration) begin
        mdl_cycle_on    = 1'b0;
        mdl_piston_duty = 7'd0;
      end
    end
    // command
    case (cmd.opcode)
      OP_SET_BOTH: begin
        if (mdl_cyclic) st = ST_BOTH_REJECT;
        else begin
          mdl_diaph_pct   = pct;
          mdl_piston_duty = pct;
        end
      end
      OP_SET_DIAPH: mdl_diaph_pct = pct;
      OP_SET_PISTON: begin
        if (mdl_cyclic) st = ST_PISTON_REJECT;
        else mdl_piston_duty = pct;
      end
      OP_TOGGLE_MODE: begin
        if (mdl_cyclic) begin
          mdl_cyclic      = 1'b0;
          mdl_cycle_on    = 1'b0;
          mdl_piston_duty = 7'd0;
        end else begin
          mdl_cyclic = 1'b1;
        end
      end
      OP_OPEN_VALVE:  mdl_valve = 1'b1;
      OP_CLOSE_VALVE: mdl_valve = 1'b0;
      default: ;
    endcase
    r.diaphragm_compare = pct_to_compare(mdl_diaph_pct);
    r.piston_compare    = pct_to_compare(mdl_piston_duty);
    r.diaphragm_level   = mdl_diaph_pct;
    r.piston_level      = mdl_piston_duty;
    r.valve_is_open     = mdl_valve;
    r.cyclic_active     = mdl_cyclic;
    r.piston_on_phase   = mdl_cycle_on;
    r.status            = st;
    return r;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, 100));
      6:                return 16'($urandom_range(101, 32767));
      7:                return 16'($urandom_range(32768, 65535));
      8:                return 16'($urandom);
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'h0000;
          1: return 16'd100;
          2: return 16'd101;
          3: return 16'hFFFF;
          4: return 16'h7FFF;
          default: return 16'h8000;
        endcase
      end
    endcase
  endfunction

  // tick-heavy command mix so cyclic timing gets exercised
  function automatic in_item_t pick_command();
    in_item_t c;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 56)      c.opcode = OP_TICK;
    else if (r < 63) c.opcode = OP_SET_BOTH;
    else if (r < 71) c.opcode = OP_SET_DIAPH;
    else if (r < 79) c.opcode = OP_SET_PISTON;
    else if (r < 83) c.opcode = OP_TOGGLE_MODE;
    else if (r < 89) c.opcode = OP_OPEN_VALVE;
    else if (r < 95) c.opcode = OP_CLOSE_VALVE;
    else if (r < 97) c.opcode = OP_UNUSED;
    else             c.opcode = 3'($urandom_range(0, 7));
    c.value = pick_value();
    return c;
  endfunction

  // present one command beat, starting at a falling edge; ends at a falling edge
  task automatic send_command(input in_item_t cmd, input bit typed, input out_item_t readout);
    int        gap;
    out_item_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    predicted = next_pump_readout(cmd);
    pending_readouts.push_back(typed ? readout : predicted);
    @(negedge clk);
  endtask

  // register write beat; valid is left high for a following write
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_INTERVAL)        mdl_interval  = data;
    else if (idx == REG_DURATION)   mdl_duration  = data;
    else if (idx == REG_PISTON_PCT) mdl_cyc_level = data[6:0];
    @(negedge clk);
  endtask

  // wait for the block to go idle, then load a timing setup
  task automatic load_timing(input logic [23:0] intv, input logic [23:0] dur,
                             input logic [6:0] lvl, input bit poke_unmapped);
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 1) @(negedge clk);
    write_reg(REG_INTERVAL, intv);
    write_reg(REG_DURATION, dur);
    write_reg(REG_PISTON_PCT, 24'(lvl));
    if (poke_unmapped) write_reg(REG_UNMAPPED, 24'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    out_item_t unused;
    unused = '0;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) steady_flow = ($urandom_range(0, 99) < 25);
      send_command(pick_command(), 1'b0, unused);
    end
    steady_flow = 1'b0;
    in_valid <= 1'b0;
  endtask

  function automatic void add_row(input logic [2:0] op, input logic [15:0] val,
                                  input bit typed, input out_item_t readout);
    cmd_row_t row;
    row.cmd.opcode = op;
    row.cmd.value  = val;
    row.typed      = typed;
    row.readout    = readout;
    cmd_table.push_back(row);
  endfunction

  // receiver stalls
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      int n;
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  task automatic report(input string field, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
      error_count++;
    end
  endtask

  // result beat check
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_readouts.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h", $time, out_data);
        error_count++;
      end else begin
        out_item_t exp_r;
        exp_r = pending_readouts.pop_front();
        report("diaphragm_compare", exp_r.diaphragm_compare, out_data.diaphragm_compare);
        report("piston_compare", exp_r.piston_compare, out_data.piston_compare);
        report("diaphragm_level", exp_r.diaphragm_level, out_data.diaphragm_level);
        report("piston_level", exp_r.piston_level, out_data.piston_level);
        report("valve_is_open", exp_r.valve_is_open, out_data.valve_is_open);
        report("cyclic_active", exp_r.cyclic_active, out_data.cyclic_active);
        report("piston_on_phase", exp_r.piston_on_phase, out_data.piston_on_phase);
        report("status", exp_r.status, out_data.status);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence
  initial begin
    out_item_t none;
    none        = '0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    error_count = 0;
    idle_cycles = 0;
    steady_flow = 1'b0;

    mdl_cyclic      = 1'b0;
    mdl_cycle_on    = 1'b0;
    mdl_diaph_pct   = 7'd0;
    mdl_piston_duty = 7'd0;
    mdl_valve       = 1'b0;
    mdl_ms_count    = 24'd0;
    mdl_interval    = 24'd0;
    mdl_duration    = 24'd0;
    mdl_cyc_level   = 7'(PCT_MAX);

    // directed rows under reset timing (cycling disabled)
    add_row(OP_TICK, 16'h0000, 1, mk_readout(0, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(OP_SET_DIAPH, 16'h7FFF, 1, mk_readout(400, 0, 100, 0, 0, 0, 0, ST_OK));
    add_row(OP_SET_DIAPH, 16'h8000, 1, mk_readout(0, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(OP_SET_DIAPH, 16'd100, 1, mk_readout(400, 0, 100, 0, 0, 0, 0, ST_OK));
    add_row(OP_SET_PISTON, 16'd101, 1, mk_readout(400, 400, 100, 100, 0, 0, 0, ST_OK));
    add_row(OP_SET_PISTON, 16'hFFFF, 1, mk_readout(400, 0, 100, 0, 0, 0, 0, ST_OK));
    add_row(OP_SET_BOTH, 16'd0, 1, mk_readout(0, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(OP_SET_BOTH, 16'd100, 1, mk_readout(400, 400, 100, 100, 0, 0, 0, ST_OK));
    add_row(OP_SET_BOTH, 16'd37, 0, none);
    add_row(OP_OPEN_VALVE, 16'h7FFF, 0, none);
    add_row(OP_UNUSED, 16'h5A5A, 0, none);
    add_row(OP_CLOSE_VALVE, 16'h8001, 0, none);
    add_row(OP_TOGGLE_MODE, 16'hFFFF, 0, none);
    add_row(OP_SET_PISTON, 16'd50, 1,
            mk_readout(148, 148, 37, 37, 0, 1, 0, ST_PISTON_REJECT));
    add_row(OP_SET_BOTH, 16'd90, 1, mk_readout(148, 148, 37, 37, 0, 1, 0, ST_BOTH_REJECT));
    add_row(OP_SET_DIAPH, 16'd1, 0, none);
    add_row(OP_TICK, 16'hA5A5, 0, none);
    add_row(OP_TOGGLE_MODE, 16'd0, 0, none);
    add_row(OP_SET_DIAPH, 16'hFFFC, 0, none);
    add_row(OP_SET_BOTH, 16'd55, 0, none);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (cmd_table[i]) send_command(cmd_table[i].cmd, cmd_table[i].typed,
                                        cmd_table[i].readout);
    in_valid <= 1'b0;

    // random phases over a spread of timing setups
    load_timing(24'd5, 24'd2, 7'd60, 1'b0);
    run_random(ITEMS_PER_SET);
    load_timing(24'd3, 24'd0, 7'd127, 1'b0);
    run_random(ITEMS_PER_SET);
    load_timing(24'd4, 24'd9, 7'd100, 1'b0);
    run_random(ITEMS_PER_SET);
    load_timing(MS_MAX, MS_MAX, 7'd0, 1'b0);
    run_random(ITEMS_PER_SET);
    load_timing(24'd0, 24'd1, 7'd100, 1'b1);
    run_random(ITEMS_PER_SET);
    load_timing(24'd1, 24'd1, 7'($urandom_range(0, 127)), 1'b0);
    run_random(ITEMS_PER_SET);
    load_timing(24'($urandom_range(1, 30)), 24'($urandom_range(0, 30)),
                7'($urandom_range(0, 127)), 1'b0);
    run_random(ITEMS_PER_SET);

    // drain and finish
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 3) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/dpcc_pkg.sv
rtl/core/dpcc_step.sv
rtl/core/dual_pump_cyclic_controller_core.sv
tb/dual_pump_cyclic_controller_core_tb.sv
